// ----- rtl/core/icdf_pkg.sv -----
// icdf_pkg: shared types for the inverse cdf table sampler
// holds the op codes, the table entry and the probe word handed along the cell chain
// no dependencies
package icdf_pkg;

    localparam int CDF_W   = 17;
    localparam int VALUE_W = 32;
    localparam int U_W     = 16;

    // input word kind, carried in tuser
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_op;

    // one table entry
    typedef struct packed {
        logic [CDF_W-1:0]   cdf;
        logic [VALUE_W-1:0] value;
    } t_entry;

    // search token moving one cell per cycle
    typedef struct packed {
        logic               valid;
        logic [U_W-1:0]     uniform;
        logic               found;
        logic [VALUE_W-1:0] value;
    } t_probe;

endpackage

// ----- rtl/core/icdf_cell.sv -----
// icdf_cell: one slot of the sorted cdf table
// keeps one entry, takes part in the ordered insert and evaluates the search token
// depends on icdf_pkg
module icdf_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  icdf_pkg::t_entry i_new,
    input  icdf_pkg::t_entry i_prev,
    input  logic             i_prev_shift,
    input  logic             i_occupied,
    input  logic             i_first,
    input  icdf_pkg::t_probe i_probe,
    output icdf_pkg::t_entry o_entry,
    output logic             o_shift,
    output icdf_pkg::t_probe o_probe
);
    import icdf_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_probe r_probe;
    t_probe n_probe;
    logic   new_before;
    logic   match;

    // new entry sorts ahead of this slot: lower cdf, or equal cdf and lower value
    assign new_before = (i_new.cdf < r_entry.cdf) ||
                        ((i_new.cdf == r_entry.cdf) && (i_new.value < r_entry.value));
    assign o_shift = i_occupied && new_before;
    assign o_entry = r_entry;

    // insert: take the neighbor's entry when it moves up, else the new one at its place
    always_comb begin
        n_entry = r_entry;
        if (i_load) begin
            if (i_prev_shift) begin
                n_entry = i_prev;
            end else if (!i_occupied || new_before) begin
                n_entry = i_new;
            end
        end
    end

    // interval test against the previous slot's cdf
    assign match = i_occupied && !i_first &&
                   (i_prev.cdf <= {1'b0, i_probe.uniform}) &&
                   ({1'b0, i_probe.uniform} < r_entry.cdf);

    always_comb begin
        n_probe = i_probe;
        if (i_probe.valid && !i_probe.found && match) begin
            n_probe.found = 1'b1;
            n_probe.value = r_entry.value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

// ----- rtl/core/inverse_cdf_table_sampler_core.sv -----
// inverse_cdf_table_sampler_core: top level of the inverse transform sampler
// a chain of icdf_cell slots plus stream handshake, fill count and output register
// depends on icdf_pkg and icdf_cell

// The block keeps up to TABLE_DEPTH (cdf, value) entries ordered by cdf, then by value,
// in a row of cells. A load word (tuser op = 0) is inserted in parallel: every cell
// compares the new entry with its own and either keeps it, takes its lower neighbor's
// entry or takes the new one; a load into a full table is dropped. A sample word
// (tuser op = 1) launches a search token that walks the row one cell per cycle, and its
// result is captured in the output register once the token leaves the last cell. No
// further word is accepted until that result has been taken; loads alone run at one per
// cycle. The result carries the value of entry i+1 for the interval cdf[i] <= U <
// cdf[i+1], or 0 with hit clear when no interval holds U or fewer than two entries exist.
module inverse_cdf_table_sampler_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [31:0] entry_value, [48:32] entry_cdf, [64:49] uniform_sample, [71:65] zero
    input  logic [71:0] i_s_axis_tdata,
    // [0] op
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] sample_value
    output logic [31:0] o_m_axis_tdata,
    // [0] hit
    output logic [0:0]  o_m_axis_tuser
);
    import icdf_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_busy;
    logic             n_busy;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic             r_out_hit;

    logic   in_fire;
    logic   out_fire;
    logic   full;
    logic   do_load;
    t_op    op;
    t_entry new_entry;
    t_probe launch;

    t_entry entries [TABLE_DEPTH];
    logic   shifts  [TABLE_DEPTH];
    t_probe probes  [TABLE_DEPTH];

    // input word unpacking
    assign op              = t_op'(i_s_axis_tuser[0]);
    assign new_entry.value = i_s_axis_tdata[31:0];
    assign new_entry.cdf   = i_s_axis_tdata[48:32];

    assign o_s_axis_tready = !r_busy;
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire = r_out_valid && i_m_axis_tready;
    assign full     = (r_count == CNT_W'(TABLE_DEPTH));
    assign do_load  = in_fire && (op == OP_LOAD) && !full;

    // search token entering the first cell
    always_comb begin
        launch         = '0;
        launch.valid   = in_fire && (op == OP_SAMPLE);
        launch.uniform = i_s_axis_tdata[64:49];
    end

    // row of cells
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_head
            icdf_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (do_load),
                .i_new        (new_entry),
                .i_prev       ('0),
                .i_prev_shift (1'b0),
                .i_occupied   (r_count > CNT_W'(k)),
                .i_first      (1'b1),
                .i_probe      (launch),
                .o_entry      (entries[k]),
                .o_shift      (shifts[k]),
                .o_probe      (probes[k])
            );
        end else begin : g_body
            icdf_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (do_load),
                .i_new        (new_entry),
                .i_prev       (entries[k-1]),
                .i_prev_shift (shifts[k-1]),
                .i_occupied   (r_count > CNT_W'(k)),
                .i_first      (1'b0),
                .i_probe      (probes[k-1]),
                .o_entry      (entries[k]),
                .o_shift      (shifts[k]),
                .o_probe      (probes[k])
            );
        end
    end

    // fill count, busy flag and output valid
    always_comb begin
        n_count     = r_count;
        n_busy      = r_busy;
        n_out_valid = r_out_valid;
        if (do_load) begin
            n_count = r_count + CNT_W'(1);
        end
        if (launch.valid) begin
            n_busy = 1'b1;
        end
        if (probes[TABLE_DEPTH-1].valid) begin
            n_out_valid = 1'b1;
        end else if (out_fire) begin
            n_out_valid = 1'b0;
            n_busy      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // result word capture
    always_ff @(posedge i_clk) begin
        if (probes[TABLE_DEPTH-1].valid) begin
            r_out_hit   <= probes[TABLE_DEPTH-1].found;
            r_out_value <= probes[TABLE_DEPTH-1].found ? probes[TABLE_DEPTH-1].value : '0;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_value;
    assign o_m_axis_tuser[0] = r_out_hit;

    // a pending result always belongs to a sample still holding the input side
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_busy)
        else $error("result pending while input side is open");

    // fill count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // a load into a full table leaves the count alone
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (op == OP_LOAD) && full) |=> $stable(r_count))
        else $error("load accepted into full table");

    // a miss reports a zero value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hit) |-> (r_out_value == '0))
        else $error("nonzero value on a miss");

    // no token reaches the end of the row without a sample in flight
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        probes[TABLE_DEPTH-1].valid |-> (r_busy && !r_out_valid))
        else $error("search token without a sample in flight");

endmodule
